// ===== rtl/ngu_pkg.sv =====
`default_nettype none
package ngu_pkg;
  localparam int MAX_BODIES = 64;
  localparam int FRAC_BITS  = 16;

  localparam int ADDR_W = $clog2(MAX_BODIES);
  localparam int CNT_W  = $clog2(MAX_BODIES + 1);
  localparam int MEM_W  = 7 * 32;

  // Squared distance fits in 68 - FRAC_BITS bits, the scaled radicand in 68 bits.
  localparam int D2_W   = 68 - FRAC_BITS;
  localparam int RAD_W  = 68;
  localparam int ROOT_W = RAD_W / 2;
  localparam int GMDT_W = 64 - FRAC_BITS;
  localparam int DIV_W  = 64;

  localparam longint NEAR_Q  = ((64'd1 << FRAC_BITS) + 5) / 10;
  localparam longint NEAR_D2 = (NEAR_Q * NEAR_Q) >> FRAC_BITS;

  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_GRAVITY = 2'd0;
  localparam logic [1:0] REG_STEP    = 2'd1;
  localparam logic [1:0] REG_ACTIVE  = 2'd2;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  localparam int IN_DATA_W  = 232;
  localparam int OUT_DATA_W = 200;
endpackage
`default_nettype wire

// ===== rtl/ngu_ram.sv =====
`default_nettype none
module ngu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/ngu_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module ngu_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [ngu_pkg::DIV_W-1:0] dividend,
  input  wire logic [ngu_pkg::DIV_W-1:0] divisor,
  output logic                          done,
  output logic      [ngu_pkg::DIV_W-1:0] quotient
);
  localparam int W = ngu_pkg::DIV_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, quo_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    rem_sh, rem_sub;
  logic          fits;

  always_comb begin
    rem_sh  = {rem_r, quo_r[W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    fits    = rem_sh >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dvs_r  <= divisor;
      cnt_r  <= CW'(W);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sub[W-1:0] : rem_sh[W-1:0];
      quo_r <= {quo_r[W-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

// ===== rtl/ngu_sqrt.sv =====
`default_nettype none
// Digit-by-digit integer square root, one root bit per cycle.
module ngu_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [ngu_pkg::RAD_W-1:0]  radicand,
  output logic                            done,
  output logic      [ngu_pkg::ROOT_W-1:0] root
);
  localparam int RW = ngu_pkg::RAD_W;
  localparam int QW = ngu_pkg::ROOT_W;
  localparam int CW = $clog2(QW + 1);

  logic [RW-1:0] rad_r;
  logic [QW+1:0] rem_r;
  logic [QW-1:0] root_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [QW+3:0] rem_sh, trial;
  logic          fits;

  always_comb begin
    rem_sh = {rem_r, rad_r[RW-1:RW-2]};
    trial  = {2'b00, root_r, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CW'(QW);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r  <= fits ? (QW+2)'(rem_sh - trial) : rem_sh[QW+1:0];
      root_r <= {root_r[QW-2:0], fits};
      rad_r  <= {rad_r[RW-3:0], 2'b00};
      cnt_r  <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

// ===== rtl/nbody_gravity_update_unit.sv =====
`default_nettype none
// Channel  | Direction | Handshake           | Payload
// in_      | slave     | in_tvalid/in_tready | in_tdata body fields, in_tuser kind
// out_     | master    | out_tvalid/out_tready | out_tdata new state, out_tuser saturated
// cfg      | APB slave | psel/penable/pready | registers at byte addresses 0, 4, 8
//
// A load is written into the body table as it is accepted. An update walks each other
// active body that is not too close through the serial square root, one quotient
// division and three axis divisions on the shared divider.
// Reset is synchronous and active low; the body table itself is not cleared.
// A finished result waits in the output register; loads are still taken meanwhile,
// and the next update's write-back waits until that result has been taken.
module nbody_gravity_update_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // body_index[5:0], load_pos_x, load_pos_y, load_pos_z, load_vel_x, load_vel_y,
  // load_vel_z, load_mass (32 bits each), zero fill
  input  wire logic [ngu_pkg::IN_DATA_W-1:0]     in_tdata,
  // kind
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_index[5:0], new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
  // new_vel_z (32 bits each), zero fill
  output logic      [ngu_pkg::OUT_DATA_W-1:0]    out_tdata,
  // saturated
  output logic                                   out_tuser,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ngu_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);
  localparam int F  = ngu_pkg::FRAC_BITS;
  localparam int AW = ngu_pkg::ADDR_W;
  localparam int CW = ngu_pkg::CNT_W;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SELF    = 5'd1;
  localparam logic [4:0] S_RD      = 5'd2;
  localparam logic [4:0] S_DIFF    = 5'd3;
  localparam logic [4:0] S_SQ      = 5'd4;
  localparam logic [4:0] S_GMDT    = 5'd5;
  localparam logic [4:0] S_ROOT_GO = 5'd6;
  localparam logic [4:0] S_ROOT_W  = 5'd7;
  localparam logic [4:0] S_QDIV_GO = 5'd8;
  localparam logic [4:0] S_QDIV_W  = 5'd9;
  localparam logic [4:0] S_UDIV_GO = 5'd10;
  localparam logic [4:0] S_UDIV_W  = 5'd11;
  localparam logic [4:0] S_MUL_H   = 5'd12;
  localparam logic [4:0] S_MUL_L   = 5'd13;
  localparam logic [4:0] S_ACC     = 5'd14;
  localparam logic [4:0] S_POS_M   = 5'd15;
  localparam logic [4:0] S_POS_A   = 5'd16;
  localparam logic [4:0] S_WB      = 5'd17;

  localparam logic [63:0] PH_CAP  = 64'd1 << (40 - (32 - F));
  localparam logic [64:0] MAG_CAP = 65'd1 << 40;
  localparam logic signed [49:0] CLIP_HI = 50'sd2147483647;
  localparam logic signed [49:0] CLIP_LO = -50'sd2147483648;

  // Saturate to 32 bits; the top bit of the result flags clipping.
  function automatic logic [32:0] clip32(input logic signed [49:0] v);
    logic [32:0] res;
    if (v > CLIP_HI) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < CLIP_LO) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  // Configuration registers.
  logic [31:0] grav_r;
  logic [15:0] step_r;
  logic [6:0]  active_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r   <= 32'd65536;
      step_r   <= 16'd1092;
      active_r <= 7'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        ngu_pkg::REG_GRAVITY: grav_r   <= pwdata;
        ngu_pkg::REG_STEP:    step_r   <= pwdata[15:0];
        ngu_pkg::REG_ACTIVE:  active_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ngu_pkg::REG_GRAVITY: prdata = grav_r;
      ngu_pkg::REG_STEP:    prdata = {16'd0, step_r};
      ngu_pkg::REG_ACTIVE:  prdata = {25'd0, active_r};
      default:              prdata = 32'd0;
    endcase
  end

  // Sequencer and datapath registers.
  logic [4:0]    state_r;
  logic [AW-1:0] idx_r;
  logic [CW-1:0] n_r, j_r;
  logic [1:0]    axis_r;
  logic          sat_r;
  logic signed [31:0] self_pos_r [3];
  logic signed [31:0] self_vel_r [3];
  logic [31:0]   self_mass_r;
  logic signed [32:0] d_r [3];
  logic [47:0]   gm_r;
  logic [ngu_pkg::GMDT_W-1:0] gmdt_r;
  logic [ngu_pkg::D2_W-1:0]   d2_r;
  logic [ngu_pkg::ROOT_W-1:0] root_r;
  logic [63:0]   q_r, ph_r, pl_r;
  logic [31:0]   u_r;
  logic signed [48:0] pm_r;
  logic          out_valid_r, out_sat_r;
  logic [ngu_pkg::OUT_DATA_W-1:0] out_data_r;

  // Memory and arithmetic units.
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic [ngu_pkg::MEM_W-1:0] mem_wdata, mem_rdata;
  logic                      div_start, div_done, sq_start, sq_done;
  logic [ngu_pkg::DIV_W-1:0] div_a, div_b, div_q;
  logic [ngu_pkg::ROOT_W-1:0] sq_root;

  ngu_ram #(.WIDTH(ngu_pkg::MEM_W), .DEPTH(ngu_pkg::MAX_BODIES)) u_table (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  ngu_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  ngu_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .radicand(ngu_pkg::RAD_W'(d2_r) << F), .done(sq_done), .root(sq_root)
  );

  logic          in_acc, in_load, in_upd, idx_ok, out_free;
  logic [AW-1:0] in_idx;
  logic signed [31:0] oth_pos [3];
  logic [31:0]   ax_abs;
  logic [63:0]   sq_prod, gm_prod, gmdt_prod;
  logic [64:0]   r_sum;
  logic [40:0]   mag;
  logic signed [49:0] vel_sum, pos_sum;
  logic [32:0]   vel_clip, pos_clip;
  logic          dx_pos, dx_neg;
  logic [CW-1:0] n_cap;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_idx    = in_tdata[AW-1:0];
  assign idx_ok    = int'(in_tdata[5:0]) < ngu_pkg::MAX_BODIES;
  assign in_load   = in_acc && (in_tuser == ngu_pkg::KIND_LOAD) && idx_ok;
  assign in_upd    = in_acc && (in_tuser == ngu_pkg::KIND_UPDATE) && idx_ok;
  assign out_free  = !out_valid_r || out_tready;
  assign n_cap     = (int'(active_r) > ngu_pkg::MAX_BODIES) ?
                     CW'(ngu_pkg::MAX_BODIES) : CW'(active_r);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      oth_pos[k] = mem_rdata[32*k +: 32];
    end
    ax_abs    = d_r[axis_r][32] ? 32'(-d_r[axis_r]) : d_r[axis_r][31:0];
    sq_prod   = 64'(ax_abs) * 64'(ax_abs);
    gm_prod   = 64'(grav_r) * 64'(mem_rdata[223:192]);
    gmdt_prod = 64'(gm_r) * 64'(step_r);
    dx_neg    = d_r[axis_r][32];
    dx_pos    = !d_r[axis_r][32] && (d_r[axis_r] != 33'sd0);
    r_sum     = {1'b0, ph_r << (32 - F)} + {1'b0, pl_r >> F};
    mag       = (ph_r > PH_CAP || r_sum > MAG_CAP) ? MAG_CAP[40:0] : r_sum[40:0];
    if (dx_pos) begin
      vel_sum = 50'(self_vel_r[axis_r]) + $signed({9'd0, mag});
    end else if (dx_neg) begin
      vel_sum = 50'(self_vel_r[axis_r]) - $signed({9'd0, mag});
    end else begin
      vel_sum = 50'(self_vel_r[axis_r]);
    end
    vel_clip = clip32(vel_sum);
    pos_sum  = 50'(self_pos_r[axis_r]) + 50'(pm_r >>> 16);
    pos_clip = clip32(pos_sum);
  end

  // Table ports: loads and write-backs never coincide with a walk read.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_idx;
    mem_wdata = in_tdata[229:6];
    mem_raddr = in_idx;
    if (in_load) begin
      mem_we = 1'b1;
    end
    if (state_r == S_WB) begin
      mem_waddr = idx_r;
      mem_wdata = {self_mass_r, self_vel_r[2], self_vel_r[1], self_vel_r[0],
                   self_pos_r[2], self_pos_r[1], self_pos_r[0]};
      mem_we    = out_free;
    end
    if (state_r == S_RD) begin
      mem_raddr = j_r[AW-1:0];
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_a     = 64'(gmdt_r) << F;
    div_b     = 64'(d2_r);
    sq_start  = (state_r == S_ROOT_GO);
    if (state_r == S_QDIV_GO) begin
      div_start = 1'b1;
    end
    if (state_r == S_UDIV_GO) begin
      div_start = 1'b1;
      div_a     = 64'(ax_abs) << F;
      div_b     = 64'(root_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // The write-back state sets the valid itself when the slot frees up.
      if (out_valid_r && out_tready && (state_r != S_WB)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_upd) begin
            idx_r   <= in_idx;
            n_r     <= n_cap;
            j_r     <= '0;
            sat_r   <= 1'b0;
            state_r <= S_SELF;
          end
        end
        S_SELF: begin
          for (int k = 0; k < 3; k++) begin
            self_pos_r[k] <= mem_rdata[32*k +: 32];
            self_vel_r[k] <= mem_rdata[96 + 32*k +: 32];
          end
          self_mass_r <= mem_rdata[223:192];
          state_r     <= S_RD;
        end
        S_RD: begin
          axis_r <= 2'd0;
          if (j_r >= n_r) begin
            state_r <= S_POS_M;
          end else if (j_r == CW'(idx_r)) begin
            j_r <= j_r + 1'b1;
          end else begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          for (int k = 0; k < 3; k++) begin
            d_r[k] <= 33'(oth_pos[k]) - 33'(self_pos_r[k]);
          end
          gm_r    <= gm_prod[63:16];
          d2_r    <= '0;
          axis_r  <= 2'd0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          d2_r <= d2_r + ngu_pkg::D2_W'(sq_prod >> F);
          if (axis_r == 2'd2) begin
            state_r <= S_GMDT;
          end else begin
            axis_r <= axis_r + 1'b1;
          end
        end
        S_GMDT: begin
          gmdt_r <= ngu_pkg::GMDT_W'(gmdt_prod >> F);
          // Pairs closer than the near limit pull nothing.
          if (64'(d2_r) < 64'(ngu_pkg::NEAR_D2) || d2_r == '0) begin
            j_r     <= j_r + 1'b1;
            state_r <= S_RD;
          end else begin
            state_r <= S_ROOT_GO;
          end
        end
        S_ROOT_GO: state_r <= S_ROOT_W;
        S_ROOT_W: begin
          if (sq_done) begin
            root_r <= sq_root;
            if (sq_root == '0) begin
              j_r     <= j_r + 1'b1;
              state_r <= S_RD;
            end else begin
              state_r <= S_QDIV_GO;
            end
          end
        end
        S_QDIV_GO: state_r <= S_QDIV_W;
        S_QDIV_W: begin
          if (div_done) begin
            q_r     <= div_q;
            axis_r  <= 2'd0;
            state_r <= S_UDIV_GO;
          end
        end
        S_UDIV_GO: state_r <= S_UDIV_W;
        S_UDIV_W: begin
          if (div_done) begin
            u_r     <= (div_q > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : div_q[31:0];
            state_r <= S_MUL_H;
          end
        end
        S_MUL_H: begin
          ph_r    <= 64'(u_r) * 64'(q_r[63:32]);
          state_r <= S_MUL_L;
        end
        S_MUL_L: begin
          pl_r    <= 64'(u_r) * 64'(q_r[31:0]);
          state_r <= S_ACC;
        end
        S_ACC: begin
          self_vel_r[axis_r] <= vel_clip[31:0];
          sat_r <= sat_r | vel_clip[32];
          if (axis_r == 2'd2) begin
            j_r     <= j_r + 1'b1;
            state_r <= S_RD;
          end else begin
            axis_r  <= axis_r + 1'b1;
            state_r <= S_UDIV_GO;
          end
        end
        S_POS_M: begin
          pm_r    <= 49'(self_vel_r[axis_r]) * $signed({33'd0, step_r});
          state_r <= S_POS_A;
        end
        S_POS_A: begin
          self_pos_r[axis_r] <= pos_clip[31:0];
          sat_r <= sat_r | pos_clip[32];
          if (axis_r == 2'd2) begin
            state_r <= S_WB;
          end else begin
            axis_r  <= axis_r + 1'b1;
            state_r <= S_POS_M;
          end
        end
        S_WB: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_sat_r   <= sat_r;
            out_data_r  <= {2'b00, self_vel_r[2], self_vel_r[1], self_vel_r[0],
                            self_pos_r[2], self_pos_r[1], self_pos_r[0],
                            6'(idx_r)};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;
endmodule
`default_nettype wire

// ===== rtl/ngu_checker.sv =====
`default_nettype none
module ngu_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [ngu_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           out_tuser,
  input wire logic                           pready
);
  // A held result keeps its valid and payload until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // An accepted update occupies the block for at least the next cycle.
  a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ngu_pkg::KIND_UPDATE) |=> !in_tready)
    else $error("input taken during update");

  // A new result only appears at the end of an update, while input is blocked.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without update");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");
endmodule

bind nbody_gravity_update_unit ngu_checker u_ngu_checker (.*);
`default_nettype wire
